[rtl/gwm_pkg.sv]
package gwm_pkg;

  localparam int MAX_PATTERN_DEFAULT = 64;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  byte_value;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic        take;
    opcode_t     opcode;
    logic [7:0]  byte_value;
  } cell_ctrl_t;

  // Handed from one cell to its right neighbor.
  typedef struct packed {
    logic head;   // neighbor is the start of the row (position zero seed)
    logic valid;  // neighbor holds a pattern byte
    logic carry;  // neighbor is reached and is a star: reach this position now
    logic adv;    // neighbor is reached and matches the current text byte
  } cell_link_t;

endpackage

[rtl/gwm_stream_if.sv]
interface gwm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/gwm_cell.sv]
module gwm_cell (
  input  logic               clk,
  input  logic               rst,
  input  gwm_pkg::cell_ctrl_t ctrl,
  input  gwm_pkg::cell_link_t left,
  output gwm_pkg::cell_link_t right,
  output logic               hit
);
  import gwm_pkg::*;

  logic [7:0] pat;
  logic       valid;
  logic       pend;       // reached before star closure
  logic       closed;
  logic       is_star;
  logic       lit_match;
  logic       pend_next;

  assign closed    = pend | left.carry;
  assign is_star   = (pat == CH_STAR);
  assign lit_match = (pat == CH_ANY) || (pat == ctrl.byte_value);

  assign right.head  = 1'b0;
  assign right.valid = valid;
  assign right.carry = closed & valid & is_star;
  assign right.adv   = closed & valid & ~is_star & lit_match;

  // An empty position that is reached marks the end of the pattern.
  assign hit = closed & ~valid;

  // A star keeps its own position; a literal hands reach to the right.
  assign pend_next = (closed & valid & is_star) | left.adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pend  <= left.head;
    end else if (ctrl.take) begin
      case (ctrl.opcode)
        OP_CLEAR: begin
          valid <= 1'b0;
          pend  <= left.head;
        end
        OP_APPEND: begin
          if (left.valid && !valid) begin
            valid <= 1'b1;
          end
          pend <= left.head;
        end
        OP_TEXT: begin
          pend <= pend_next;
        end
        default: begin
          pend <= left.head;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take && ctrl.opcode == OP_APPEND && left.valid && !valid) begin
      pat <= ctrl.byte_value;
    end
  end

endmodule

[rtl/gwm_out_buf.sv]
module gwm_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gwm_pkg::result_t push_data,
  output logic             can_push,
  gwm_stream_if.source     result
);
  import gwm_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign can_push       = ~skid_valid;
  assign pop            = out_valid & result.ready;
  assign result.valid   = out_valid;
  assign result.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/wildcard_glob_match.sv]
// The result word is registered in the output buffer when its end-of-text word is accepted.
// Throughput: one word per cycle for every opcode while the skid entry is free; each text byte
// updates all pattern positions at once via the star-reach carry that ripples along the cells.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset (synchronous): empty pattern, overflow clear, position zero reached, buffer empty.
module wildcard_glob_match #(
  parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  gwm_stream_if.sink   cmd,
  gwm_stream_if.source result
);
  import gwm_pkg::*;

  cell_ctrl_t             ctrl;
  cell_link_t             links [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hits;
  logic                   take;
  logic                   can_push;
  logic                   push;
  logic                   full;
  logic                   ovf;
  logic                   end_pend;
  logic                   end_closed;
  logic                   hit_any;
  result_t                res;

  assign cmd.ready       = can_push;
  assign take            = cmd.valid & cmd.ready;
  assign ctrl.take       = take;
  assign ctrl.opcode     = cmd.payload.opcode;
  assign ctrl.byte_value = cmd.payload.byte_value;

  assign links[0] = '{head: 1'b1, valid: 1'b1, carry: 1'b0, adv: 1'b0};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    gwm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (links[i]),
      .right (links[i+1]),
      .hit   (hits[i])
    );
  end

  // Position past the last cell: reachable only with a full pattern.
  assign full       = links[MAX_PATTERN].valid;
  assign end_closed = end_pend | links[MAX_PATTERN].carry;
  assign hit_any    = (|hits) | end_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_pend <= 1'b0;
      ovf      <= 1'b0;
    end else if (take) begin
      case (cmd.payload.opcode)
        OP_CLEAR: begin
          end_pend <= 1'b0;
          ovf      <= 1'b0;
        end
        OP_APPEND: begin
          end_pend <= 1'b0;
          if (full) begin
            ovf <= 1'b1;
          end
        end
        OP_TEXT: begin
          end_pend <= links[MAX_PATTERN].adv;
        end
        default: begin
          end_pend <= 1'b0;
        end
      endcase
    end
  end

  assign push         = take & (cmd.payload.opcode == OP_END);
  assign res.matched  = hit_any & ~ovf;
  assign res.overflow = ovf;

  gwm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .can_push  (can_push),
    .result    (result)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import gwm_pkg::*;

  localparam int MAXP = MAX_PATTERN_DEFAULT;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gwm_stream_if #(.payload_t(cmd_t))    cmd_ch ();
  gwm_stream_if #(.payload_t(result_t)) res_ch ();

  wildcard_glob_match dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch)
  );

  // Tracks the set of reachable pattern positions and holds the match words still owed.
  class glob_tracker;
    logic [7:0]  pat_bytes [MAXP];
    int unsigned pat_len;
    bit [MAXP:0] reach;
    bit          overflowed;
    result_t     match_q [$];
    int          errors;

    function new();
      pat_len    = 0;
      overflowed = 1'b0;
      errors     = 0;
      restart_text();
    endfunction

    function bit [MAXP:0] spread_stars(bit [MAXP:0] r);
      for (int i = 0; i < pat_len; i++) begin
        if (r[i] && pat_bytes[i] == CH_STAR) r[i+1] = 1'b1;
      end
      return r;
    endfunction

    function void restart_text();
      reach    = '0;
      reach[0] = 1'b1;
      reach    = spread_stars(reach);
    endfunction

    function void take_text(logic [7:0] b);
      bit [MAXP:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (reach[i]) begin
          if (pat_bytes[i] == CH_STAR) nxt[i] = 1'b1;
          else if (pat_bytes[i] == CH_ANY || pat_bytes[i] == b) nxt[i+1] = 1'b1;
        end
      end
      reach = spread_stars(nxt);
    endfunction

    function void note_word(cmd_t w);
      result_t r;
      case (w.opcode)
        OP_CLEAR: begin
          pat_len    = 0;
          overflowed = 1'b0;
          restart_text();
        end
        OP_APPEND: begin
          if (pat_len < MAXP) begin
            pat_bytes[pat_len] = w.byte_value;
            pat_len++;
          end else begin
            overflowed = 1'b1;
          end
          restart_text();
        end
        OP_TEXT: take_text(w.byte_value);
        default: begin
          r.matched  = reach[pat_len] && !overflowed;
          r.overflow = overflowed;
          match_q.push_back(r);
          restart_text();
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (match_q.size() == 0) begin
        report($sformatf("result word with none pending (matched=%0b overflow=%0b)",
                         got.matched, got.overflow));
      end else begin
        want = match_q.pop_front();
        if (got.matched !== want.matched)
          report($sformatf("matched=%0b, want %0b", got.matched, want.matched));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow=%0b, want %0b", got.overflow, want.overflow));
      end
    endtask

    function int pending();
      return match_q.size();
    endfunction
  endclass

  glob_tracker tracker = new();

  bit         calm = 1'b0;
  int         words_sent = 0;
  logic [7:0] cur_pat [$];

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    res_ch.ready   = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) tracker.note_word(cmd_ch.payload);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) tracker.check_result(res_ch.payload);
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Enter and leave at a falling edge.
  task automatic send_word(opcode_t op, logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 32) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= cmd_t'{opcode: op, byte_value: b};
    do @(posedge clk); while (!cmd_ch.ready);
    words_sent++;
    if (op == OP_CLEAR) cur_pat.delete();
    else if (op == OP_APPEND && cur_pat.size() < MAXP) cur_pat.push_back(b);
    @(negedge clk);
  endtask

  task automatic wait_results_settled();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2:       return "b";
      3, 4:    return CH_STAR;
      5:       return CH_ANY;
      6:       return "^";
      7:       return "$";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return CH_STAR;
      6:       return CH_ANY;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Build a text that fits the current pattern; mutate to break it now and then.
  task automatic send_text_for(bit mutate);
    logic [7:0] p;
    for (int i = 0; i < cur_pat.size(); i++) begin
      p = cur_pat[i];
      if (mutate && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) != 0) send_word(OP_TEXT, pick_text_byte());
      end else if (p == CH_STAR) begin
        repeat ($urandom_range(0, 3)) send_word(OP_TEXT, pick_text_byte());
      end else if (p == CH_ANY) begin
        send_word(OP_TEXT, 8'($urandom_range(1, 255)));
      end else begin
        send_word(OP_TEXT, p);
      end
    end
    if (mutate && $urandom_range(0, 3) == 0) send_word(OP_TEXT, pick_text_byte());
    send_word(OP_END, 8'($urandom_range(1, 255)));
  endtask

  initial begin
    int  sel;
    int  len;
    bit  drained;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty pattern: empty text matches, any text does not.
    send_word(OP_END, 8'hFF);
    send_word(OP_TEXT, 8'h01);
    send_word(OP_END, 8'h01);
    // Star alone matches empty text.
    send_word(OP_APPEND, CH_STAR);
    send_word(OP_END, 8'h80);
    send_word(OP_APPEND, CH_ANY);
    send_word(OP_TEXT, 8'hFF);
    send_word(OP_TEXT, "x");
    send_word(OP_END, 8'h7F);
    // Anchor markers are plain literals.
    send_word(OP_APPEND, "^");
    send_word(OP_TEXT, "q");
    send_word(OP_TEXT, "^");
    send_word(OP_END, 8'h01);
    send_word(OP_TEXT, "q");
    send_word(OP_END, 8'h01);
    // Zero byte is an ordinary literal.
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_APPEND, "$");
    send_word(OP_APPEND, 8'h00);
    send_word(OP_TEXT, "$");
    send_word(OP_TEXT, 8'h00);
    send_word(OP_END, 8'h01);
    send_word(OP_TEXT, 8'h80);
    send_word(OP_END, 8'h01);
    wait_results_settled();

    // Fill the pattern to capacity, then push past it.
    send_word(OP_CLEAR, 8'h01);
    for (int i = 0; i < MAXP; i++) send_word(OP_APPEND, (i == 10) ? CH_STAR : CH_ANY);
    repeat (70) send_word(OP_TEXT, 8'($urandom_range(1, 255)));
    send_word(OP_END, 8'h01);
    send_word(OP_APPEND, "z");
    send_word(OP_END, 8'h01);
    repeat (70) send_word(OP_TEXT, 8'($urandom_range(1, 255)));
    send_word(OP_END, 8'h01);
    send_word(OP_CLEAR, 8'h01);
    send_word(OP_END, 8'h01);
    wait_results_settled();

    while (words_sent < 650) begin
      calm = (words_sent >= 420 && words_sent < 540);
      sel  = $urandom_range(0, 99);
      if (sel < 20) begin
        send_word(OP_CLEAR, 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 19) == 0) len = $urandom_range(7, MAXP + 2);
        else len = $urandom_range(0, 6);
        repeat (len) send_word(OP_APPEND, pick_pattern_byte());
      end else if (sel < 85) begin
        send_text_for($urandom_range(0, 2) == 0);
      end else if (sel < 93) begin
        repeat ($urandom_range(0, 8)) send_word(OP_TEXT, pick_text_byte());
        send_word(OP_END, 8'($urandom_range(1, 255)));
      end else begin
        send_word(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
      end
      if (!drained && words_sent >= 600) begin
        wait_results_settled();
        drained = 1'b1;
      end
    end
    calm = 1'b0;

    wait_results_settled();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gwm_pkg.sv
rtl/gwm_stream_if.sv
rtl/gwm_cell.sv
rtl/gwm_out_buf.sv
rtl/wildcard_glob_match.sv
tb/tb_top.sv
